// File: hw/rtl/rtufr_pkg.sv
// Shared constants, opcodes and timer control types for the RS485 RTU frame receiver.
package rtufr_pkg;

    localparam int BUFFER_DEPTH      = 256;
    localparam int RESPONSE_PRESCALE = 100;
    localparam int MS_TO_UNITS       = 10;

    localparam int ADDR_W     = $clog2(BUFFER_DEPTH);
    localparam int COUNT_W    = $clog2(BUFFER_DEPTH + 1);
    localparam int PRESCALE_W = (RESPONSE_PRESCALE > 1) ? $clog2(RESPONSE_PRESCALE) : 1;

    localparam int OP_W      = 4;
    localparam int BYTE_W    = 8;
    localparam int TMS_W     = 16;
    localparam int IDX_W     = 8;
    localparam int CNT_OUT_W = 9;
    localparam int SIL_W     = 16;
    localparam int RSP_W     = 20;

    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;

    localparam logic [SIL_W-1:0]     SILENCE_LIMIT_RESET   = 16'd2005;
    localparam logic [RSP_W-1:0]     RESPONSE_RELOAD_RESET = 20'd10000;
    localparam logic [PADDR_W-3:0]   REG_SILENCE_LIMIT     = '0;

    typedef enum logic [OP_W-1:0] {
        OP_TICK      = 4'd0,
        OP_RX_BYTE   = 4'd1,
        OP_ARM       = 4'd2,
        OP_STOP      = 4'd3,
        OP_FLUSH     = 4'd4,
        OP_CLR_FRAME = 4'd5,
        OP_CLR_TMO   = 4'd6,
        OP_READ      = 4'd7,
        OP_TX_START  = 4'd8,
        OP_TX_DONE   = 4'd9
    } opcode_t;

    typedef struct packed {
        logic tick;
        logic arm;
        logic stop;
        logic byte_clr;
    } tmr_ctrl_t;

    typedef struct packed {
        logic sil_exp;
        logic rsp_exp;
        logic running;
    } tmr_stat_t;

endpackage

// File: hw/rtl/rtufr_if.sv
// Valid/ready channel interfaces for the frame receiver request and result transactions.
interface rtufr_in_if;
    import rtufr_pkg::*;

    logic               valid;
    logic               ready;
    logic [OP_W-1:0]    opcode;
    logic [BYTE_W-1:0]  rx_byte;
    logic [TMS_W-1:0]   resp_timeout;
    logic [IDX_W-1:0]   read_index;

    modport source (output valid, output opcode, output rx_byte, output resp_timeout,
                    output read_index, input ready);
    modport sink   (input valid, input opcode, input rx_byte, input resp_timeout,
                    input read_index, output ready);
endinterface

interface rtufr_out_if;
    import rtufr_pkg::*;

    logic                 valid;
    logic                 ready;
    logic                 driver_enable;
    logic                 frame_ready;
    logic                 response_timed_out;
    logic                 tx_complete;
    logic [CNT_OUT_W-1:0] byte_count;
    logic [BYTE_W-1:0]    read_data;
    logic                 timers_running;

    modport source (output valid, output driver_enable, output frame_ready,
                    output response_timed_out, output tx_complete, output byte_count,
                    output read_data, output timers_running, input ready);
    modport sink   (input valid, input driver_enable, input frame_ready,
                    input response_timed_out, input tx_complete, input byte_count,
                    input read_data, input timers_running, output ready);
endinterface

// File: hw/rtl/rs485_rtu_frame_receiver.sv
// Top level of the RS485 RTU receive framer: request pipeline, frame buffer, flags, APB register.
// Takes one transaction per clock while the result channel is not stalled; each passes one input
// register stage and one result register stage, with all flag, count and timer updates done
// in the single step between them and the frame buffer read registered into the result stage.
// While a result waits, the input register still takes one more transaction. The frame buffer
// holds BUFFER_DEPTH bytes, needs no clearing after reset and only returns bytes stored since
// the last flush. APB register at byte address 0: silence_limit (16 bits, reset 2005).
module rs485_rtu_frame_receiver (
    input  logic                          clk,
    input  logic                          rst_n,
    rtufr_in_if.sink                      item,
    rtufr_out_if.source                   result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [rtufr_pkg::PADDR_W-1:0] paddr,
    input  logic [rtufr_pkg::PDATA_W-1:0] pwdata,
    output logic [rtufr_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import rtufr_pkg::*;

    localparam int CMP_W = IDX_W + COUNT_W;

    // input register stage
    logic               a_valid_reg;
    logic [OP_W-1:0]    a_op_reg;
    logic [BYTE_W-1:0]  a_byte_reg;
    logic [TMS_W-1:0]   a_tms_reg;
    logic [IDX_W-1:0]   a_idx_reg;

    // result stage and block state
    logic               b_valid_reg;
    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               frame_reg,   frame_next;
    logic               timeout_reg, timeout_next;
    logic               txdone_reg,  txdone_next;
    logic               driver_reg,  driver_next;
    logic [BYTE_W-1:0]  rd_q_reg;
    logic               rd_hit_reg,  rd_hit_next;
    logic [SIL_W-1:0]   silence_limit_reg;

    logic [BYTE_W-1:0]  frame_mem [BUFFER_DEPTH];

    logic               in_accept;
    logic               b_advance;
    logic               cnt_full;
    logic               mem_we;
    logic               cfg_wr;
    logic               cfg_sel;
    tmr_ctrl_t          tctrl;
    tmr_stat_t          tstat;

    assign b_advance  = a_valid_reg && (!b_valid_reg || result.ready);
    assign item.ready = !a_valid_reg || b_advance;
    assign in_accept  = item.valid && item.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
                a_valid_reg <= 1'b1;
            else if (b_advance)
                a_valid_reg <= 1'b0;

            if (b_advance)
                b_valid_reg <= 1'b1;
            else if (result.ready)
                b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            a_op_reg   <= item.opcode;
            a_byte_reg <= item.rx_byte;
            a_tms_reg  <= item.resp_timeout;
            a_idx_reg  <= item.read_index;
        end
    end

    // timer control
    assign tctrl.tick     = b_advance && (a_op_reg == OP_TICK);
    assign tctrl.arm      = b_advance && (a_op_reg == OP_ARM);
    assign tctrl.stop     = b_advance && (a_op_reg == OP_STOP);
    assign tctrl.byte_clr = b_advance && (a_op_reg == OP_RX_BYTE) && !driver_reg;

    rtufr_timers u_timers (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (tctrl),
        .silence_limit (silence_limit_reg),
        .resp_timeout  (a_tms_reg),
        .stat          (tstat)
    );

    assign cnt_full = (count_reg == COUNT_W'(BUFFER_DEPTH));
    assign mem_we   = tctrl.byte_clr && !cnt_full;

    always_comb
    begin
        count_next   = count_reg;
        frame_next   = frame_reg;
        timeout_next = timeout_reg;
        txdone_next  = txdone_reg;
        driver_next  = driver_reg;
        rd_hit_next  = 1'b0;

        case (a_op_reg)
            OP_TICK:
            begin
                if (tstat.sil_exp)
                begin
                    if (count_reg != '0)
                        frame_next = 1'b1;
                end
                else if (tstat.rsp_exp)
                begin
                    timeout_next = 1'b1;
                end
            end
            OP_RX_BYTE:
            begin
                if (!driver_reg && !cnt_full)
                    count_next = count_reg + 1'b1;
            end
            OP_FLUSH:
            begin
                count_next   = '0;
                frame_next   = 1'b0;
                timeout_next = 1'b0;
            end
            OP_CLR_FRAME:
                frame_next = 1'b0;
            OP_CLR_TMO:
                timeout_next = 1'b0;
            OP_READ:
                rd_hit_next = CMP_W'(a_idx_reg) < CMP_W'(count_reg);
            OP_TX_START:
            begin
                txdone_next = 1'b0;
                driver_next = 1'b1;
            end
            OP_TX_DONE:
            begin
                driver_next = 1'b0;
                txdone_next = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg   <= '0;
            frame_reg   <= 1'b0;
            timeout_reg <= 1'b0;
            txdone_reg  <= 1'b0;
            driver_reg  <= 1'b0;
        end
        else if (b_advance)
        begin
            count_reg   <= count_next;
            frame_reg   <= frame_next;
            timeout_reg <= timeout_next;
            txdone_reg  <= txdone_next;
            driver_reg  <= driver_next;
        end
    end

    // frame buffer: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
            frame_mem[count_reg[ADDR_W-1:0]] <= a_byte_reg;
        if (b_advance)
        begin
            rd_q_reg   <= frame_mem[ADDR_W'(a_idx_reg)];
            rd_hit_reg <= rd_hit_next;
        end
    end

    // APB register
    assign pready  = 1'b1;
    assign cfg_sel = (paddr[PADDR_W-1:2] == REG_SILENCE_LIMIT);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = cfg_sel ? PDATA_W'(silence_limit_reg) : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            silence_limit_reg <= SILENCE_LIMIT_RESET;
        else if (cfg_wr && cfg_sel)
            silence_limit_reg <= pwdata[SIL_W-1:0];
    end

    // result channel
    assign result.valid              = b_valid_reg;
    assign result.driver_enable      = driver_reg;
    assign result.frame_ready        = frame_reg;
    assign result.response_timed_out = timeout_reg;
    assign result.tx_complete        = txdone_reg;
    assign result.byte_count         = CNT_OUT_W'(count_reg);
    assign result.read_data          = rd_hit_reg ? rd_q_reg : '0;
    assign result.timers_running     = tstat.running;

    // assertions
    a_stall_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
        (b_valid_reg && !result.ready) |=> ($stable(count_reg) && $stable(frame_reg)
            && $stable(timeout_reg) && $stable(driver_reg)))
        else $error("state changed while result stalled");

    a_flush_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (b_advance && (a_op_reg == OP_FLUSH)) |=> ((count_reg == '0) && !frame_reg
            && !timeout_reg))
        else $error("flush did not clear count and flags");

    a_silence_stops: assert property (@(posedge clk) disable iff (!rst_n)
        (b_advance && tstat.sil_exp) |=> !tstat.running)
        else $error("timers still running after silence expiry");

    a_driver_blocks_rx: assert property (@(posedge clk) disable iff (!rst_n)
        (b_advance && (a_op_reg == OP_RX_BYTE) && driver_reg) |=> $stable(count_reg))
        else $error("byte stored while driver enabled");

endmodule

// File: hw/rtl/rtufr_timers.sv
// Inter-character silence timer, response prescaler and response timer.
module rtufr_timers (
    input  logic                        clk,
    input  logic                        rst_n,
    input  rtufr_pkg::tmr_ctrl_t        ctrl,
    input  logic [rtufr_pkg::SIL_W-1:0] silence_limit,
    input  logic [rtufr_pkg::TMS_W-1:0] resp_timeout,
    output rtufr_pkg::tmr_stat_t        stat
);
    import rtufr_pkg::*;

    localparam logic [PRESCALE_W-1:0] PRESCALE_LAST = PRESCALE_W'(RESPONSE_PRESCALE - 1);

    logic [SIL_W-1:0]      sil_cnt_reg,    sil_cnt_next;
    logic [RSP_W-1:0]      rsp_cnt_reg,    rsp_cnt_next;
    logic [RSP_W-1:0]      rsp_reload_reg, rsp_reload_next;
    logic [PRESCALE_W-1:0] pre_cnt_reg,    pre_cnt_next;
    logic                  running_reg,    running_next;
    logic                  sil_exp;
    logic                  rsp_exp;

    always_comb
    begin
        sil_cnt_next    = sil_cnt_reg;
        rsp_cnt_next    = rsp_cnt_reg;
        rsp_reload_next = rsp_reload_reg;
        pre_cnt_next    = pre_cnt_reg;
        running_next    = running_reg;
        sil_exp         = 1'b0;
        rsp_exp         = 1'b0;

        if (ctrl.tick && running_reg)
        begin
            if (sil_cnt_reg >= silence_limit)
                sil_exp = 1'b1;
            else
                sil_cnt_next = sil_cnt_reg + 1'b1;

            if (pre_cnt_reg == PRESCALE_LAST)
            begin
                pre_cnt_next = '0;
                if (rsp_cnt_reg >= rsp_reload_reg)
                    rsp_exp = 1'b1;
                else
                    rsp_cnt_next = rsp_cnt_reg + 1'b1;
            end
            else
            begin
                pre_cnt_next = pre_cnt_reg + 1'b1;
            end

            if (sil_exp || rsp_exp)
                running_next = 1'b0;
        end

        if (ctrl.byte_clr)
            sil_cnt_next = '0;

        if (ctrl.arm)
        begin
            rsp_reload_next = RSP_W'(resp_timeout) * RSP_W'(MS_TO_UNITS);
            rsp_cnt_next    = '0;
            pre_cnt_next    = '0;
            sil_cnt_next    = '0;
            running_next    = 1'b1;
        end

        if (ctrl.stop)
            running_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sil_cnt_reg    <= '0;
            rsp_cnt_reg    <= '0;
            rsp_reload_reg <= RESPONSE_RELOAD_RESET;
            pre_cnt_reg    <= '0;
            running_reg    <= 1'b0;
        end
        else
        begin
            sil_cnt_reg    <= sil_cnt_next;
            rsp_cnt_reg    <= rsp_cnt_next;
            rsp_reload_reg <= rsp_reload_next;
            pre_cnt_reg    <= pre_cnt_next;
            running_reg    <= running_next;
        end
    end

    assign stat.sil_exp = sil_exp;
    assign stat.rsp_exp = rsp_exp;
    assign stat.running = running_reg;

endmodule
